@@ rtl/polyline_subdivider_unit_defines.svh @@
// ---------------------------------------------------------------------------
// Polyline subdivider assertion macros
// Shared property templates used by the checks at the end of the sequencer module.
// ---------------------------------------------------------------------------
`ifndef POLYLINE_SUBDIVIDER_UNIT_DEFINES_SVH
`define POLYLINE_SUBDIVIDER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSD_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PSD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/psd_pkg.sv @@
// ---------------------------------------------------------------------------
// Polyline subdivider package
// Widths, shared types and small constant functions of the subdivider.
// ---------------------------------------------------------------------------
package psd_pkg;

	localparam int COORD_BITS     = 24;
	localparam int DIMENSIONS     = 2;
	localparam int MAX_SUBDIV     = 15;

	localparam int SUBDIV_IN_BITS = 4;
	// Latched subdivision count and point index within a segment.
	localparam int SUB_BITS       = $clog2(MAX_SUBDIV + 1);
	// Points per segment, up to MAX_SUBDIV + 1.
	localparam int N_BITS         = $clog2(MAX_SUBDIV + 2);
	// Remainder of a division by the point count.
	localparam int REM_BITS       = SUB_BITS;
	// Remainder before correction, below twice the point count.
	localparam int R0_BITS        = N_BITS + 1;
	localparam int RECIP_BITS     = COORD_BITS + 1;

	localparam int DIM_H = 0;
	localparam int DIM_W = 1;

	localparam longint unsigned ONE = 64'd1 << COORD_BITS;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [COORD_BITS:0]   wide_t;
	typedef coord_t [DIMENSIONS-1:0]      point_t;

	// Per-cycle command to the interpolation lanes.
	typedef struct packed {
		logic load;
		logic mul;
		logic fix;
		logic step;
	} cmd_t;

	function automatic logic [SUB_BITS-1:0] sat_subdiv(input logic [SUBDIV_IN_BITS-1:0] s);
		if (int'(s) > MAX_SUBDIV) begin
			return SUB_BITS'(MAX_SUBDIV);
		end
		return SUB_BITS'(s);
	endfunction

	// floor(2^COORD_BITS / n) for every legal point count.
	function automatic logic [RECIP_BITS-1:0] recip(input logic [N_BITS-1:0] n);
		case (int'(n))
			1:  return RECIP_BITS'(ONE / 1);
			2:  return RECIP_BITS'(ONE / 2);
			3:  return RECIP_BITS'(ONE / 3);
			4:  return RECIP_BITS'(ONE / 4);
			5:  return RECIP_BITS'(ONE / 5);
			6:  return RECIP_BITS'(ONE / 6);
			7:  return RECIP_BITS'(ONE / 7);
			8:  return RECIP_BITS'(ONE / 8);
			9:  return RECIP_BITS'(ONE / 9);
			10: return RECIP_BITS'(ONE / 10);
			11: return RECIP_BITS'(ONE / 11);
			12: return RECIP_BITS'(ONE / 12);
			13: return RECIP_BITS'(ONE / 13);
			14: return RECIP_BITS'(ONE / 14);
			15: return RECIP_BITS'(ONE / 15);
			16: return RECIP_BITS'(ONE / 16);
			17: return RECIP_BITS'(ONE / 17);
			18: return RECIP_BITS'(ONE / 18);
			19: return RECIP_BITS'(ONE / 19);
			20: return RECIP_BITS'(ONE / 20);
			21: return RECIP_BITS'(ONE / 21);
			22: return RECIP_BITS'(ONE / 22);
			23: return RECIP_BITS'(ONE / 23);
			24: return RECIP_BITS'(ONE / 24);
			25: return RECIP_BITS'(ONE / 25);
			26: return RECIP_BITS'(ONE / 26);
			27: return RECIP_BITS'(ONE / 27);
			28: return RECIP_BITS'(ONE / 28);
			29: return RECIP_BITS'(ONE / 29);
			30: return RECIP_BITS'(ONE / 30);
			31: return RECIP_BITS'(ONE / 31);
			32: return RECIP_BITS'(ONE / 32);
			default: return '0;
		endcase
	endfunction

endpackage

@@ rtl/psd_lane.sv @@
// ---------------------------------------------------------------------------
// Polyline subdivider interpolation lane
// Walks one coordinate of a segment in equal steps of (q - p) / n.
// ---------------------------------------------------------------------------
module psd_lane (
	input  logic                       clk,
	input  psd_pkg::cmd_t              cmd,
	input  psd_pkg::coord_t            p,
	input  psd_pkg::coord_t            q,
	input  logic [psd_pkg::N_BITS-1:0] n,
	output psd_pkg::coord_t            value
);
	import psd_pkg::*;

	// The running point is kept as acc + rem / n with 0 <= rem < n, and each
	// step adds the exact floor quotient and remainder of (q - p) / n.
	logic [N_BITS-1:0]     n_q;
	coord_t                p_q;
	logic                  neg_q;
	logic [COORD_BITS-1:0] mag_q;
	logic [COORD_BITS-1:0] q0_q;
	wide_t                 qd_q;
	logic [REM_BITS-1:0]   rd_q;
	wide_t                 acc_q;
	logic [REM_BITS-1:0]   rem_q;

	wide_t                 diff;
	wide_t                 diff_abs;
	logic [2*COORD_BITS:0] prod;
	logic [R0_BITS-1:0]    qn_lo;
	logic [R0_BITS-1:0]    r0;
	logic [R0_BITS-1:0]    r1;
	logic                  ge;
	logic [COORD_BITS:0]   q1;
	wide_t                 q1s;
	wide_t                 qd_nx;
	logic [REM_BITS-1:0]   rd_nx;
	logic [R0_BITS-1:0]    n_ext;
	logic [R0_BITS-1:0]    t_sum;
	logic                  carry;
	logic [R0_BITS-1:0]    twice;
	logic                  round_up;
	wide_t                 rounded;

	assign n_ext    = R0_BITS'(n_q);

	assign diff     = wide_t'(q) - wide_t'(p);
	assign diff_abs = diff[COORD_BITS] ? -diff : diff;

	// Quotient estimate from the reciprocal; it is low by at most one.
	assign prod = (2*COORD_BITS+1)'(mag_q) * (2*COORD_BITS+1)'(recip(n_q));

	// The remainder before correction is below 2n, so its low bits are enough.
	assign qn_lo = R0_BITS'(q0_q[R0_BITS-1:0] * n_ext);
	assign r0    = mag_q[R0_BITS-1:0] - qn_lo;
	assign ge    = (r0 >= n_ext);
	assign r1    = ge ? (r0 - n_ext) : r0;
	assign q1    = {1'b0, q0_q} + (COORD_BITS+1)'(ge);
	assign q1s   = wide_t'(q1);

	// Turn the magnitude division into a floor division of the signed step.
	always_comb begin
		if (!neg_q) begin
			qd_nx = q1s;
			rd_nx = REM_BITS'(r1);
		end else if (r1 == '0) begin
			qd_nx = -q1s;
			rd_nx = '0;
		end else begin
			qd_nx = -q1s - wide_t'(1);
			rd_nx = REM_BITS'(n_ext - r1);
		end
	end

	assign t_sum = R0_BITS'(rem_q) + R0_BITS'(rd_q);
	assign carry = (t_sum >= n_ext);

	// Round to nearest with ties away from zero.
	assign twice    = R0_BITS'({rem_q, 1'b0});
	assign round_up = acc_q[COORD_BITS] ? (twice > n_ext) : (twice >= n_ext);
	assign rounded  = acc_q + wide_t'(round_up);
	assign value    = rounded[COORD_BITS-1:0];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q   <= n;
			p_q   <= p;
			neg_q <= diff[COORD_BITS];
			mag_q <= diff_abs[COORD_BITS-1:0];
		end
		if (cmd.mul) begin
			q0_q <= prod[2*COORD_BITS-1:COORD_BITS];
		end
		if (cmd.fix) begin
			qd_q  <= qd_nx;
			rd_q  <= rd_nx;
			acc_q <= wide_t'(p_q);
			rem_q <= '0;
		end
		if (cmd.step) begin
			acc_q <= acc_q + qd_q + wide_t'(carry);
			rem_q <= REM_BITS'(carry ? (t_sum - n_ext) : t_sum);
		end
	end

endmodule

@@ rtl/psd_ctrl.sv @@
// ---------------------------------------------------------------------------
// Polyline subdivider sequencer
// Tracks the group, picks segment endpoints and steps the lanes.
// ---------------------------------------------------------------------------
module psd_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         point_valid,
	output logic                         point_ready,
	input  psd_pkg::point_t              pt,
	input  logic                         group_closed,
	input  logic [psd_pkg::SUBDIV_IN_BITS-1:0] subdivisions,
	input  logic                         group_last,
	input  logic                         slot_free,
	output psd_pkg::cmd_t                cmd,
	output psd_pkg::point_t              seg_p,
	output psd_pkg::point_t              seg_q,
	output logic [psd_pkg::N_BITS-1:0]   seg_n,
	output logic                         cap,
	output logic                         cap_last
);
	import psd_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_LOAD = 3'd1;
	localparam logic [2:0] S_MUL  = 3'd2;
	localparam logic [2:0] S_FIX  = 3'd3;
	localparam logic [2:0] S_EMIT = 3'd4;

	logic [2:0]          state_q;
	logic                in_group_q;
	logic                seg2_q;
	point_t              first_q;
	point_t              prev_q;
	point_t              cur_q;
	logic                closed_q;
	logic                last_q;
	logic [SUB_BITS-1:0] subdiv_q;
	logic [SUB_BITS-1:0] k_q;
	logic [SUB_BITS-1:0] k_last_q;

	logic                acc;
	logic                final_k;

	assign point_ready = (state_q == S_IDLE);
	assign acc         = point_valid && point_ready;
	assign final_k     = (k_q == k_last_q);

	// Segment one runs from the previous point to this one, segment two is the
	// closing segment or the lone final point.
	assign seg_p = seg2_q ? cur_q : prev_q;
	assign seg_q = (seg2_q && closed_q) ? first_q : cur_q;
	assign seg_n = N_BITS'(subdiv_q) + N_BITS'(1);

	assign cmd.load = (state_q == S_LOAD);
	assign cmd.mul  = (state_q == S_MUL);
	assign cmd.fix  = (state_q == S_FIX);
	assign cmd.step = cap;

	assign cap      = (state_q == S_EMIT) && slot_free;
	assign cap_last = final_k && (seg2_q || !last_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			in_group_q <= 1'b0;
			seg2_q     <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						in_group_q <= !group_last;
						if (in_group_q) begin
							seg2_q  <= 1'b0;
							state_q <= S_LOAD;
						end else if (group_last) begin
							seg2_q  <= 1'b1;
							state_q <= S_LOAD;
						end
					end
				end
				S_LOAD: state_q <= S_MUL;
				S_MUL:  state_q <= S_FIX;
				S_FIX:  state_q <= S_EMIT;
				S_EMIT: begin
					if (cap && final_k) begin
						if (!seg2_q && last_q) begin
							seg2_q  <= 1'b1;
							state_q <= S_LOAD;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			cur_q    <= pt;
			closed_q <= group_closed;
			last_q   <= group_last;
			if (!in_group_q) begin
				first_q  <= pt;
				prev_q   <= pt;
				subdiv_q <= sat_subdiv(subdivisions);
			end
		end
		if (state_q == S_LOAD) begin
			prev_q   <= cur_q;
			k_q      <= '0;
			k_last_q <= (seg2_q && !closed_q) ? '0 : subdiv_q;
		end
		if (cap && !final_k) begin
			k_q <= k_q + SUB_BITS'(1);
		end
	end

`include "polyline_subdivider_unit_defines.svh"

	`PSD_ASSERT_NEXT(a_start_silent, acc && !in_group_q && !group_last, state_q == S_IDLE, "group start produced work")
	`PSD_ASSERT_SAME(a_k_bound, state_q == S_EMIT, k_q <= k_last_q, "point index past segment end")
	`PSD_ASSERT_SAME(a_seg2_on_last, seg2_q && state_q != S_IDLE, last_q, "closing segment on inner point")
	`PSD_ASSERT_NEXT(a_last_to_idle, cap && cap_last, state_q == S_IDLE, "transaction end did not return to idle")

endmodule

@@ rtl/psd_merge.sv @@
// ---------------------------------------------------------------------------
// Polyline subdivider output merge
// Joins the lane coordinates into one result transaction and holds it.
// ---------------------------------------------------------------------------
module psd_merge (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cap,
	input  logic            cap_last,
	input  psd_pkg::point_t lane_value,
	input  logic            result_ready,
	output logic            result_valid,
	output psd_pkg::coord_t out_h,
	output psd_pkg::coord_t out_w,
	output logic            run_last,
	output logic            slot_free
);
	import psd_pkg::*;

	logic   valid_q;
	point_t pt_q;
	logic   last_q;

	assign slot_free    = !valid_q || result_ready;
	assign result_valid = valid_q;
	assign out_h        = pt_q[DIM_H];
	assign out_w        = pt_q[DIM_W];
	assign run_last     = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (slot_free) begin
			valid_q <= cap;
		end
	end

	always_ff @(posedge clk) begin
		if (cap && slot_free) begin
			pt_q   <= lane_value;
			last_q <= cap_last;
		end
	end

endmodule

@@ rtl/polyline_subdivider_unit.sv @@
// ---------------------------------------------------------------------------
// Polyline subdivider
// Linear subdivision of 2-D polylines with rounded fixed-point results.
// ---------------------------------------------------------------------------
// Points arrive one transaction at a time on the point channel; the first
// point of a group latches the subdivision count a (saturated to MAX_SUBDIV)
// and yields nothing unless it also ends the group. Each later point yields
// a+1 result transactions along the segment from the previous point, and the
// last point of a group adds the closing segment (closed group) or the point
// itself (open group). run_last marks the final result of each point.
// Sequencing: a point is taken while the sequencer is idle; each segment
// then passes through its setup states (endpoint load, reciprocal multiply,
// quotient correction in the lanes) before its result points, which are
// emitted at one result per cycle while the output slot is free. A
// finished result waits in the output register while the next point is
// taken, so the point side is not held up by a slow consumer until the
// sequencer needs to emit again.
// ---------------------------------------------------------------------------
module polyline_subdivider_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               point_valid,
	output logic                               point_ready,
	input  psd_pkg::coord_t                    coord_h,
	input  psd_pkg::coord_t                    coord_w,
	input  logic                               group_closed,
	input  logic [psd_pkg::SUBDIV_IN_BITS-1:0] subdivisions,
	input  logic                               group_last,
	output logic                               result_valid,
	input  logic                               result_ready,
	output psd_pkg::coord_t                    out_h,
	output psd_pkg::coord_t                    out_w,
	output logic                               run_last
);
	import psd_pkg::*;

	point_t            in_pt;
	point_t            seg_p;
	point_t            seg_q;
	point_t            lane_value;
	logic [N_BITS-1:0] seg_n;
	cmd_t              cmd;
	logic              cap;
	logic              cap_last;
	logic              slot_free;

	assign in_pt[DIM_H] = coord_h;
	assign in_pt[DIM_W] = coord_w;

	// The sequencer owns the group state (first point, previous point, count)
	// and issues the same command to every lane each cycle.
	psd_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.point_valid  (point_valid),
		.point_ready  (point_ready),
		.pt           (in_pt),
		.group_closed (group_closed),
		.subdivisions (subdivisions),
		.group_last   (group_last),
		.slot_free    (slot_free),
		.cmd          (cmd),
		.seg_p        (seg_p),
		.seg_q        (seg_q),
		.seg_n        (seg_n),
		.cap          (cap),
		.cap_last     (cap_last)
	);

	// One interpolation lane per coordinate; they run in lockstep.
	for (genvar g = 0; g < DIMENSIONS; g++) begin : g_lane
		psd_lane u_lane (
			.clk   (clk),
			.cmd   (cmd),
			.p     (seg_p[g]),
			.q     (seg_q[g]),
			.n     (seg_n),
			.value (lane_value[g])
		);
	end

	// The merge stage packs the lane outputs into one result transaction.
	psd_merge u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.cap          (cap),
		.cap_last     (cap_last),
		.lane_value   (lane_value),
		.result_ready (result_ready),
		.result_valid (result_valid),
		.out_h        (out_h),
		.out_w        (out_w),
		.run_last     (run_last),
		.slot_free    (slot_free)
	);

endmodule
